// ===== design/csvscan_pkg.sv =====
// csvscan_pkg: shared types, character codes and defaults for the csv cell scanner
// used by csvscan_core, csvscan_rspbuf and csv_cell_boundary_scanner_unit
// no dependencies
`default_nettype none

package csvscan_pkg;

   // default bounds for the row, column and byte counters
   localparam int unsigned MAX_ROWS_DEF  = 256;
   localparam int unsigned MAX_COLS_DEF  = 256;
   localparam int unsigned MAX_BYTES_DEF = 262144;

   // character codes
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   // record kinds
   localparam logic REC_CELL    = 1'b0;
   localparam logic REC_SUMMARY = 1'b1;

   // widths of the result packing
   localparam int unsigned RSP_DATA_W = 56;

   // one result record
   typedef struct packed {
      logic        record_type;
      logic [7:0]  row_index;
      logic [7:0]  column_index;
      logic [17:0] byte_offset;
      logic [8:0]  column_count;
      logic [8:0]  row_count;
      logic        overflow;
      logic        final_record;
   } rec_type;

   // up to three records produced by one input byte, in delivery order
   typedef struct packed {
      logic [1:0]          count;
      rec_type [2:0]       rec;
   } batch_type;

endpackage

`default_nettype wire

// ===== design/csvscan_core.sv =====
// csvscan_core: scanner state and the single-pass decode of one byte
// depends on csvscan_pkg
// produces a batch of up to three records per processed byte
`default_nettype none

module csvscan_core #(
   parameter int unsigned MAX_ROWS  = csvscan_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS  = csvscan_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_BYTES = csvscan_pkg::MAX_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   fire,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   final_byte,
   output csvscan_pkg::batch_type      batch
);

   localparam int unsigned ROW_W = $clog2(MAX_ROWS);
   localparam int unsigned COL_W = $clog2(MAX_COLS);
   localparam int unsigned POS_W = $clog2(MAX_BYTES);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_COLS - 1);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_BYTES - 1);

   typedef struct packed {
      logic [1:0]       qd;
      logic [7:0]       pb;
      logic             pv;
      logic             sk;
      logic             rs;
      logic [POS_W-1:0] pos;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [COL_W-1:0] wid;
      logic             ovf;
   } scan_type;

   typedef struct packed {
      scan_type            st;
      logic                em;
      csvscan_pkg::rec_type rec;
   } proc_res_type;

   function automatic logic is_sep(logic [7:0] b);
      return b == csvscan_pkg::CH_COMMA || b == csvscan_pkg::CH_LF ||
             b == csvscan_pkg::CH_CR;
   endfunction

   // cell start record with the counters cut to the field widths
   function automatic csvscan_pkg::rec_type cell_rec(logic [ROW_W-1:0] row,
                                                     logic [COL_W-1:0] col,
                                                     logic [POS_W-1:0] off,
                                                     logic ovf);
      csvscan_pkg::rec_type r;
      logic [31:0] row_w;
      logic [31:0] col_w;
      logic [31:0] off_w;
      row_w = 32'(row);
      col_w = 32'(col);
      off_w = 32'(off);
      r = '0;
      r.record_type  = csvscan_pkg::REC_CELL;
      r.row_index    = row_w[7:0];
      r.column_index = col_w[7:0];
      r.byte_offset  = off_w[17:0];
      r.overflow     = ovf;
      return r;
   endfunction

   // end of stream summary
   function automatic csvscan_pkg::rec_type sum_rec(logic [ROW_W-1:0] row,
                                                    logic [COL_W-1:0] wid,
                                                    logic ovf);
      csvscan_pkg::rec_type r;
      logic [31:0] rcnt;
      logic [31:0] ccnt;
      rcnt = 32'(row) + 32'd1;
      ccnt = 32'(wid) + 32'd1;
      r = '0;
      r.record_type  = csvscan_pkg::REC_SUMMARY;
      r.column_count = ccnt[8:0];
      r.row_count    = rcnt[8:0];
      r.overflow     = ovf;
      r.final_record = 1'b1;
      return r;
   endfunction

   // decision on a held byte c, given the byte n that follows it
   function automatic proc_res_type proc_fn(scan_type s, logic [7:0] c, logic [7:0] n,
                                            logic [POS_W-1:0] off, logic has_next);
      proc_res_type r;
      r.st  = s;
      r.em  = 1'b0;
      r.rec = '0;
      if (c == csvscan_pkg::CH_QUOTE) begin
         if (s.qd == 2'd0) begin
            r.st.qd = 2'd1;
         end else if (is_sep(n)) begin
            r.st.qd = s.qd - 2'd1;
         end
      end else if (c == csvscan_pkg::CH_COMMA && s.qd == 2'd0) begin
         if (s.col >= COL_LAST) begin
            r.st.ovf = 1'b1;
         end else begin
            r.st.col = s.col + COL_W'(1);
         end
         if (!is_sep(n)) begin
            r.em  = 1'b1;
            r.rec = cell_rec(r.st.row, r.st.col, off, r.st.ovf);
         end
      end else if (has_next && ((c == csvscan_pkg::CH_CR && n == csvscan_pkg::CH_LF) ||
                                (c == csvscan_pkg::CH_LF && n == csvscan_pkg::CH_CR))) begin
         if (s.col > s.wid) begin
            r.st.wid = s.col;
         end
         r.st.col = '0;
         r.st.sk  = 1'b1;
      end
      return r;
   endfunction

   scan_type             st_ff;
   scan_type             st_in;
   scan_type             s;
   proc_res_type         pa;
   proc_res_type         pb;
   logic                 ea;
   logic                 eb;
   csvscan_pkg::rec_type ra;
   csvscan_pkg::rec_type rb;
   csvscan_pkg::rec_type rsum;
   logic [POS_W-1:0]     off_b;

   // single pass over the byte: held byte, row opening, position, end of stream
   always_comb begin
      s     = st_ff;
      off_b = st_ff.pos;
      ea    = 1'b0;
      eb    = 1'b0;
      ra    = '0;
      rb    = '0;
      rsum  = '0;
      pa    = '0;
      pb    = '0;

      // held byte, now that its successor is known
      if (s.pv) begin
         pa   = proc_fn(s, s.pb, data_byte, off_b, 1'b1);
         s    = pa.st;
         ea   = pa.em;
         ra   = pa.rec;
         s.pv = 1'b0;
      end

      // second byte of a row end pair is dropped
      if (s.sk) begin
         s.sk = 1'b0;
         if (!final_byte) begin
            s.rs = 1'b1;
         end
      end else begin
         if (s.rs) begin
            s.rs = 1'b0;
            if (s.row >= ROW_LAST) begin
               s.ovf = 1'b1;
            end else begin
               s.row = s.row + ROW_W'(1);
            end
            if (!is_sep(data_byte)) begin
               ea = 1'b1;
               ra = cell_rec(s.row, '0, off_b, s.ovf);
            end
            if (data_byte == csvscan_pkg::CH_QUOTE && s.qd < 2'd3) begin
               s.qd = s.qd + 2'd1;
            end
         end else if (off_b == '0 && data_byte != csvscan_pkg::CH_COMMA) begin
            ea = 1'b1;
            ra = cell_rec('0, '0, '0, s.ovf);
         end
         s.pb = data_byte;
         s.pv = 1'b1;
      end

      // saturating byte position
      if (s.pos >= POS_LAST) begin
         s.ovf = 1'b1;
      end else begin
         s.pos = s.pos + POS_W'(1);
      end

      // flush the held byte against a zero and close the stream
      if (final_byte) begin
         if (s.pv) begin
            pb   = proc_fn(s, s.pb, 8'h00, s.pos, 1'b0);
            s    = pb.st;
            eb   = pb.em;
            rb   = pb.rec;
            s.pv = 1'b0;
         end
         rsum = sum_rec(s.row, s.wid, s.ovf);
         s    = '0;
      end
      st_in = s;
   end

   // pack the emitted records in order
   always_comb begin
      batch.count  = 2'(ea) + 2'(eb) + 2'(final_byte);
      batch.rec[0] = ea ? ra : (eb ? rb : rsum);
      batch.rec[1] = (ea && eb) ? rb : rsum;
      batch.rec[2] = rsum;
   end

   // scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
      end else if (fire) begin
         st_ff <= st_in;
      end
   end

   // end of stream leaves the scanner in its reset state
   a_fin_clears: assert property (@(posedge clock) disable iff (reset)
      fire && final_byte |=> st_ff.pos == '0 && !st_ff.pv && st_ff.row == '0)
      else $error("state not cleared after last byte");

   // the summary is always last in its batch
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      fire && final_byte |-> batch.count != 2'd0 &&
         batch.rec[batch.count - 2'd1].final_record)
      else $error("summary not at end of batch");

   // no byte is held while the second byte of a row end pair is being dropped
   a_no_skip_pend: assert property (@(posedge clock) disable iff (reset)
      st_ff.sk |-> !st_ff.pv)
      else $error("pending byte held during pair skip");

endmodule

`default_nettype wire

// ===== design/csvscan_rspbuf.sv =====
// csvscan_rspbuf: three-entry result queue that sends one record per transfer
// depends on csvscan_pkg
// entry zero is the output register; entries shift down on each transfer
`default_nettype none

module csvscan_rspbuf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire csvscan_pkg::batch_type  batch,
   output logic                         free,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output csvscan_pkg::rec_type         head
);

   logic [1:0]                  cnt_ff;
   logic [1:0]                  cnt_in;
   csvscan_pkg::rec_type [2:0]  slot_ff;
   csvscan_pkg::rec_type [2:0]  slot_in;
   logic                        pop;

   assign rsp_tvalid = cnt_ff != 2'd0;
   assign head       = slot_ff[0];
   assign pop        = rsp_tvalid && rsp_tready;
   // empty now, or emptied by the transfer in this cycle
   assign free       = cnt_ff == 2'd0 || (cnt_ff == 2'd1 && rsp_tready);

   // next fill and entries
   always_comb begin
      cnt_in  = cnt_ff;
      slot_in = slot_ff;
      if (load) begin
         cnt_in  = batch.count;
         slot_in = batch.rec;
      end else if (pop) begin
         cnt_in     = cnt_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // entries
   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("batch loaded over pending results");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      pop && !load |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("fill count did not drop on transfer");

   a_final_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && head.final_record |-> head.record_type == csvscan_pkg::REC_SUMMARY)
      else $error("final flag on a cell record");

endmodule

`default_nettype wire

// ===== design/csv_cell_boundary_scanner_unit.sv =====
// csv_cell_boundary_scanner_unit: top level of the csv cell boundary scanner
// depends on csvscan_pkg, csvscan_core and csvscan_rspbuf
//
// Usage: one text byte per transfer on the req_ channel, req_tlast on the
// last byte of a file. For each non-empty cell the rsp_ channel sends a cell
// record (row, column, byte offset); after the last byte it sends a summary
// record (column and row counts) with rsp_tlast set. rsp_tuser tells the two
// kinds apart. A byte is held in the input register, decoded in one pass into
// up to three records, and those wait in a three-entry queue whose head is
// the output register.
// A byte waits in the input register until the queue can take its records.
// Throughput: one byte per cycle while each byte yields at most one record and the
// receiver is ready; a byte that yields more records holds the input until the
// queue, which sends one record per cycle while the receiver is ready, holds one.
// Reset clears the scanner counters and the queue; the block then waits for
// the first byte of a new file. After each last byte the scanner returns to
// that state by itself. When the receiver stalls, the queue and then the
// input register fill and req_tready drops; nothing is lost.
`default_nettype none

module csv_cell_boundary_scanner_unit #(
   parameter int unsigned MAX_ROWS  = csvscan_pkg::MAX_ROWS_DEF,
   parameter int unsigned MAX_COLS  = csvscan_pkg::MAX_COLS_DEF,
   parameter int unsigned MAX_BYTES = csvscan_pkg::MAX_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // data_byte
   input  wire logic                              req_tlast,   // final_byte
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // row_index, column_index, byte_offset, column_count, row_count, overflow, zero pad
   output logic [csvscan_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                   rsp_tuser,   // record_type
   output logic                                   rsp_tlast    // final_record
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [7:0]             in_byte_ff;
   logic                   in_last_ff;
   logic                   fire;
   logic                   free;
   csvscan_pkg::batch_type batch;
   csvscan_pkg::rec_type   head;

   // decode the held byte once the queue can take its records
   assign fire        = in_valid_ff && free;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   csvscan_core #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_BYTES (MAX_BYTES)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .final_byte (in_last_ff),
      .batch      (batch)
   );

   csvscan_rspbuf u_rspbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .batch      (batch),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .head       (head)
   );

   // result packing
   assign rsp_tdata = {3'b000, head.overflow, head.row_count, head.column_count,
                       head.byte_offset, head.column_index, head.row_index};
   assign rsp_tuser = head.record_type;
   assign rsp_tlast = head.final_record;

endmodule

`default_nettype wire

// ===== tb/tb_csv_cell_boundary_scanner_unit.sv =====
// tb_csv_cell_boundary_scanner_unit: self-checking bench for the csv cell boundary scanner
// drives byte files on req_, predicts cell and summary records, checks them on rsp_
// depends on csvscan_pkg and csv_cell_boundary_scanner_unit
`default_nettype none

module tb_csv_cell_boundary_scanner_unit;

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned PHASE_ITEMS = 36;
   localparam int unsigned HOLD_CYCLES = 80;

   // one row of the directed table; typed rows carry the cell record they must yield
   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      logic [7:0]  row;
      logic [7:0]  col;
      logic [17:0] off;
   } stim_row_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_tvalid;
   logic                               req_tready;
   logic [7:0]                         req_tdata;   // data_byte
   logic                               req_tlast;   // final_byte
   logic                               rsp_tvalid;
   logic                               rsp_tready;
   // row_index, column_index, byte_offset, column_count, row_count, overflow, zero pad
   logic [csvscan_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                               rsp_tuser;   // record_type
   logic                               rsp_tlast;   // final_record

   int unsigned failures = 0;
   int unsigned cycle_count = 0;
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned random_items = 0;
   bit          hold_request = 1'b0;
   int unsigned hold_left = 0;

   // scanner shadow state
   logic [1:0]  quote_level;
   logic [7:0]  held_byte;
   logic        held_valid;
   logic        pair_tail;
   logic        row_opening;
   logic [17:0] next_offset;
   logic [7:0]  cur_row;
   logic [7:0]  cur_col;
   logic [7:0]  widest_col;
   logic        ovf_sticky;

   csvscan_pkg::rec_type byte_records[$];    // records caused by the byte just transferred
   csvscan_pkg::rec_type pending_records[$]; // records still owed by the block
   logic [7:0]           file_bytes[$];

   stim_row_type directed_rows [0:23] = '{
      '{8'h61,                 1'b0, 1'b1, 8'd0, 8'd0, 18'd0},   // first byte opens cell 0,0
      '{csvscan_pkg::CH_COMMA, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{8'hff,                 1'b0, 1'b1, 8'd0, 8'd1, 18'd2},   // cell after a comma
      '{csvscan_pkg::CH_COMMA, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_COMMA, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},   // empty cell, no record
      '{csvscan_pkg::CH_QUOTE, 1'b0, 1'b1, 8'd0, 8'd3, 18'd5},
      '{csvscan_pkg::CH_COMMA, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},   // comma hidden by quotes
      '{csvscan_pkg::CH_QUOTE, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_QUOTE, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},   // quote before quote
      '{csvscan_pkg::CH_COMMA, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_CR,    1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_LF,    1'b0, 1'b0, 8'd0, 8'd0, 18'd0},   // cr lf ends the row
      '{csvscan_pkg::CH_QUOTE, 1'b0, 1'b1, 8'd1, 8'd0, 18'd12},  // row opening quote
      '{csvscan_pkg::CH_QUOTE, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_LF,    1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_CR,    1'b0, 1'b0, 8'd0, 8'd0, 18'd0},   // lf cr ends the row
      '{csvscan_pkg::CH_COMMA, 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},   // row opens with a comma
      '{8'h00,                 1'b0, 1'b1, 8'd2, 8'd1, 18'd17},
      '{csvscan_pkg::CH_COMMA, 1'b1, 1'b0, 8'd0, 8'd0, 18'd0},   // trailing comma
      '{8'h7a,                 1'b1, 1'b0, 8'd0, 8'd0, 18'd0},   // one byte file
      '{csvscan_pkg::CH_COMMA, 1'b1, 1'b0, 8'd0, 8'd0, 18'd0},   // one comma file
      '{8'h41,                 1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_CR,    1'b0, 1'b0, 8'd0, 8'd0, 18'd0},
      '{csvscan_pkg::CH_LF,    1'b1, 1'b0, 8'd0, 8'd0, 18'd0}    // pair closing the file
   };

   csv_cell_boundary_scanner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // clock, period 4
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic is_separator(input logic [7:0] b);
      return b == csvscan_pkg::CH_COMMA || b == csvscan_pkg::CH_LF ||
             b == csvscan_pkg::CH_CR;
   endfunction

   task automatic clear_scan_state();
      quote_level = 2'd0;
      held_byte   = 8'd0;
      held_valid  = 1'b0;
      pair_tail   = 1'b0;
      row_opening = 1'b0;
      next_offset = 18'd0;
      cur_row     = 8'd0;
      cur_col     = 8'd0;
      widest_col  = 8'd0;
      ovf_sticky  = 1'b0;
   endtask

   task automatic add_record(input logic kind, input logic [7:0] row, input logic [7:0] col,
                             input logic [17:0] off, input logic [8:0] ccount,
                             input logic [8:0] rcount, input logic fin);
      csvscan_pkg::rec_type r;
      r.record_type  = kind;
      r.row_index    = row;
      r.column_index = col;
      r.byte_offset  = off;
      r.column_count = ccount;
      r.row_count    = rcount;
      r.overflow     = ovf_sticky;
      r.final_record = fin;
      byte_records.push_back(r);
   endtask

   // resolve the held byte now that the byte after it is known
   task automatic resolve_held(input logic [7:0] c, input logic [7:0] n,
                               input logic [17:0] off_n, input logic has_next);
      if (c == csvscan_pkg::CH_QUOTE) begin
         if (quote_level == 2'd0)
            quote_level = 2'd1;
         else if (is_separator(n))
            quote_level = quote_level - 2'd1;
      end else if (c == csvscan_pkg::CH_COMMA && quote_level == 2'd0) begin
         if (cur_col >= 8'(csvscan_pkg::MAX_COLS_DEF - 1))
            ovf_sticky = 1'b1;
         else
            cur_col = cur_col + 8'd1;
         if (!is_separator(n))
            add_record(csvscan_pkg::REC_CELL, cur_row, cur_col, off_n, 9'd0, 9'd0, 1'b0);
      end else if (has_next && ((c == csvscan_pkg::CH_CR && n == csvscan_pkg::CH_LF) ||
                                (c == csvscan_pkg::CH_LF && n == csvscan_pkg::CH_CR))) begin
         if (cur_col > widest_col)
            widest_col = cur_col;
         cur_col   = 8'd0;
         pair_tail = 1'b1;
      end
   endtask

   // advance the shadow scanner by one byte, filling byte_records
   task automatic scan_byte(input logic [7:0] b, input logic fin);
      logic [17:0] off_b;
      off_b = next_offset;
      byte_records.delete();
      if (held_valid) begin
         resolve_held(held_byte, b, off_b, 1'b1);
         held_valid = 1'b0;
      end
      if (pair_tail) begin
         pair_tail = 1'b0;
         if (!fin)
            row_opening = 1'b1;
      end else begin
         if (row_opening) begin
            row_opening = 1'b0;
            if (cur_row >= 8'(csvscan_pkg::MAX_ROWS_DEF - 1))
               ovf_sticky = 1'b1;
            else
               cur_row = cur_row + 8'd1;
            if (!is_separator(b))
               add_record(csvscan_pkg::REC_CELL, cur_row, 8'd0, off_b, 9'd0, 9'd0, 1'b0);
            if (b == csvscan_pkg::CH_QUOTE && quote_level < 2'd3)
               quote_level = quote_level + 2'd1;
         end else if (off_b == 18'd0 && b != csvscan_pkg::CH_COMMA) begin
            add_record(csvscan_pkg::REC_CELL, 8'd0, 8'd0, 18'd0, 9'd0, 9'd0, 1'b0);
         end
         held_byte  = b;
         held_valid = 1'b1;
      end
      if (next_offset >= 18'(csvscan_pkg::MAX_BYTES_DEF - 1))
         ovf_sticky = 1'b1;
      else
         next_offset = next_offset + 18'd1;
      if (fin) begin
         if (held_valid) begin
            resolve_held(held_byte, 8'h00, next_offset, 1'b0);
            held_valid = 1'b0;
         end
         add_record(csvscan_pkg::REC_SUMMARY, 8'd0, 8'd0, 18'd0,
                    {1'b0, widest_col} + 9'd1, {1'b0, cur_row} + 9'd1, 1'b1);
         clear_scan_state();
      end
   endtask

   // offer one byte, wait for its transfer, then queue what it must produce
   task automatic deliver(input logic [7:0] b, input logic fin, input logic typed,
                          input csvscan_pkg::rec_type want);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      scan_byte(b, fin);
      if (typed)
         pending_records.push_back(want);
      else
         foreach (byte_records[i])
            pending_records.push_back(byte_records[i]);
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) begin
         deliver(file_bytes[i], i == file_bytes.size() - 1, 1'b0, '0);
         random_items++;
      end
      file_bytes.delete();
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (is_separator(b) || b == csvscan_pkg::CH_QUOTE);
      return b;
   endfunction

   function automatic logic [7:0] rough_byte();
      case ($urandom_range(0, 5))
         0: return csvscan_pkg::CH_QUOTE;
         1: return csvscan_pkg::CH_COMMA;
         2: return csvscan_pkg::CH_CR;
         3: return csvscan_pkg::CH_LF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_row_end();
      if ($urandom_range(0, 1)) begin
         file_bytes.push_back(csvscan_pkg::CH_CR);
         file_bytes.push_back(csvscan_pkg::CH_LF);
      end else begin
         file_bytes.push_back(csvscan_pkg::CH_LF);
         file_bytes.push_back(csvscan_pkg::CH_CR);
      end
   endtask

   // well formed file: rows of plain, empty and quoted cells
   task automatic build_table_file();
      int unsigned rows;
      int unsigned cols;
      int unsigned len;
      rows = $urandom_range(1, 4);
      cols = $urandom_range(1, 4);
      for (int unsigned r = 0; r < rows; r++) begin
         for (int unsigned c = 0; c < cols; c++) begin
            if (c != 0)
               file_bytes.push_back(csvscan_pkg::CH_COMMA);
            len = $urandom_range(0, 3);
            case ($urandom_range(0, 3))
               0: ;
               3: begin
                  file_bytes.push_back(csvscan_pkg::CH_QUOTE);
                  repeat (len) begin
                     case ($urandom_range(0, 3))
                        0: file_bytes.push_back(csvscan_pkg::CH_COMMA);
                        1: begin
                           file_bytes.push_back(csvscan_pkg::CH_QUOTE);
                           file_bytes.push_back(csvscan_pkg::CH_QUOTE);
                        end
                        default: file_bytes.push_back(text_byte());
                     endcase
                  end
                  file_bytes.push_back(csvscan_pkg::CH_QUOTE);
               end
               default: repeat (len + 1) file_bytes.push_back(text_byte());
            endcase
         end
         if (r + 1 < rows || $urandom_range(0, 1))
            push_row_end();
      end
      if (file_bytes.size() == 0)
         file_bytes.push_back(text_byte());
   endtask

   // broken file: unclosed quotes at row starts, or a jumble of quotes, separators and random bytes
   task automatic build_broken_file();
      if ($urandom_range(0, 1)) begin
         repeat ($urandom_range(3, 5)) begin
            file_bytes.push_back(csvscan_pkg::CH_QUOTE);
            file_bytes.push_back(text_byte());
            push_row_end();
         end
         file_bytes.push_back(csvscan_pkg::CH_QUOTE);
      end else begin
         repeat ($urandom_range(4, 20)) file_bytes.push_back(rough_byte());
      end
   endtask

   // random files until the phase has sent its share of bytes
   task automatic run_random_phase();
      int unsigned start_items;
      int unsigned pick;
      start_items = random_items;
      while (random_items - start_items < PHASE_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            build_table_file();
         else if (pick < 8)
            build_broken_file();
         else
            repeat ($urandom_range(1, 24)) file_bytes.push_back(8'($urandom_range(0, 255)));
         send_file();
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // check each record transfer against the oldest owed record
   always @(posedge clock) begin
      csvscan_pkg::rec_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_records.size() == 0) begin
            $error("record with none owed: tuser %0d tdata %h tlast %0d",
                   rsp_tuser, rsp_tdata, rsp_tlast);
            failures++;
         end else begin
            want = pending_records.pop_front();
            compare_field("record_type", 32'(want.record_type), 32'(rsp_tuser));
            compare_field("row_index", 32'(want.row_index), 32'(rsp_tdata[7:0]));
            compare_field("column_index", 32'(want.column_index), 32'(rsp_tdata[15:8]));
            compare_field("byte_offset", 32'(want.byte_offset), 32'(rsp_tdata[33:16]));
            compare_field("column_count", 32'(want.column_count), 32'(rsp_tdata[42:34]));
            compare_field("row_count", 32'(want.row_count), 32'(rsp_tdata[51:43]));
            compare_field("overflow", 32'(want.overflow), 32'(rsp_tdata[52]));
            compare_field("final_record", 32'(want.final_record), 32'(rsp_tlast));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("csv_cell_boundary_scanner_unit regression: fail");
         $finish;
      end
   end

   // main sequence
   initial begin
      csvscan_pkg::rec_type want;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tlast  = 1'b0;
      clear_scan_state();
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         want = '{csvscan_pkg::REC_CELL, directed_rows[i].row, directed_rows[i].col,
                  directed_rows[i].off, 9'd0, 9'd0, 1'b0, 1'b0};
         deliver(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed, want);
      end

      // random files under two idling mixes
      req_idle_pct = 15;
      rsp_idle_pct = 86;
      run_random_phase();
      req_idle_pct = 86;
      rsp_idle_pct = 15;
      run_random_phase();

      // long receiver hold-off while the sender streams without gaps
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 1'b1;
      run_random_phase();

      // column saturation: one row with more columns than the column bound
      file_bytes.push_back(text_byte());
      repeat (256) file_bytes.push_back(csvscan_pkg::CH_COMMA);
      file_bytes.push_back(text_byte());
      send_file();

      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then let the pipeline settle
      while (pending_records.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      if (failures == 0)
         $display("csv_cell_boundary_scanner_unit regression: pass");
      else
         $display("csv_cell_boundary_scanner_unit regression: fail");
      $finish;
   end

endmodule

`default_nettype wire
